>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of i_clk outside reset.
`define PFUB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`endif

>>> hw/rtl/pfub_pkg.sv
package pfub_pkg;

    localparam int DIM_W      = 13;
    localparam int PIX_W      = 32;
    localparam int BCNT_W     = 3;
    localparam int PADDR_W    = 5;
    localparam int FIFO_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_BYTES,
        KIND_565,
        KIND_4444,
        KIND_5551
    } t_kind;

    typedef enum logic [2:0] {
        LAY_A,
        LAY_L,
        LAY_LA,
        LAY_RGB,
        LAY_RGBA
    } t_layout;

    localparam logic [2:0] REG_SOURCE_KIND    = 3'd0;
    localparam logic [2:0] REG_DEST_LAYOUT    = 3'd1;
    localparam logic [2:0] REG_PIXELS_PER_ROW = 3'd2;
    localparam logic [2:0] REG_ROW_COUNT      = 3'd3;
    localparam logic [2:0] REG_DEST_ROW_PITCH = 3'd4;
    localparam logic [2:0] REG_DEST_START     = 3'd5;

    typedef struct packed {
        t_kind              source_kind;
        logic [2:0]         dest_layout;
        logic [DIM_W-1:0]   pixels_per_row;
        logic [DIM_W-1:0]   row_count;
        logic [15:0]        dest_row_pitch;
        logic [31:0]        dest_start;
    } t_cfg;

    typedef struct packed {
        logic [31:0]        address;
        logic [PIX_W-1:0]   source_word;
        t_layout            layout;
        logic [BCNT_W-1:0]  byte_count;
        logic               row_end;
        logic               frame_last;
    } t_cmd;

endpackage

>>> hw/rtl/pfub_front.sv
module pfub_front #(
    parameter int MAX_DIM   = 4096,
    parameter int ADDR_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pfub_pkg::t_cfg              i_cfg,
    input  logic                        i_restart,
    input  logic                        i_accept,
    input  logic [pfub_pkg::PIX_W-1:0]  i_source_word,
    output pfub_pkg::t_cmd              o_cmd
);
    import pfub_pkg::*;

    localparam int CNT_W = (MAX_DIM > 8192) ? DIM_W :
                           ((MAX_DIM < 2) ? 1 : $clog2(MAX_DIM));

    logic [CNT_W-1:0]     r_col, n_col;
    logic [CNT_W-1:0]     r_row, n_row;
    logic [ADDR_BITS-1:0] r_base, n_base;
    logic [ADDR_BITS-1:0] r_addr, n_addr;

    logic [CNT_W:0]       w_width;
    logic [CNT_W:0]       w_height;
    t_layout              w_layout;
    logic [BCNT_W-1:0]    w_nbytes;
    logic                 w_rend;
    logic                 w_last;
    logic [ADDR_BITS-1:0] w_start;
    logic [ADDR_BITS-1:0] w_next_base;

    always_comb begin
        if (i_cfg.pixels_per_row == '0) begin
            w_width = (CNT_W+1)'(1);
        end else if (32'(i_cfg.pixels_per_row) > MAX_DIM) begin
            w_width = (CNT_W+1)'(MAX_DIM);
        end else begin
            w_width = (CNT_W+1)'(i_cfg.pixels_per_row);
        end
        if (i_cfg.row_count == '0) begin
            w_height = (CNT_W+1)'(1);
        end else if (32'(i_cfg.row_count) > MAX_DIM) begin
            w_height = (CNT_W+1)'(MAX_DIM);
        end else begin
            w_height = (CNT_W+1)'(i_cfg.row_count);
        end
    end

    always_comb begin
        unique case (i_cfg.dest_layout)
            LAY_A:   begin w_layout = LAY_A;    w_nbytes = 3'd1; end
            LAY_L:   begin w_layout = LAY_L;    w_nbytes = 3'd1; end
            LAY_LA:  begin w_layout = LAY_LA;   w_nbytes = 3'd2; end
            LAY_RGB: begin w_layout = LAY_RGB;  w_nbytes = 3'd3; end
            default: begin w_layout = LAY_RGBA; w_nbytes = 3'd4; end
        endcase
    end

    assign w_rend      = ((CNT_W+1)'(r_col) + (CNT_W+1)'(1)) >= w_width;
    assign w_last      = w_rend && (((CNT_W+1)'(r_row) + (CNT_W+1)'(1)) >= w_height);
    assign w_start     = ADDR_BITS'(i_cfg.dest_start);
    assign w_next_base = r_base + ADDR_BITS'(i_cfg.dest_row_pitch);

    assign o_cmd.address     = 32'(r_addr);
    assign o_cmd.source_word = i_source_word;
    assign o_cmd.layout      = w_layout;
    assign o_cmd.byte_count  = w_nbytes;
    assign o_cmd.row_end     = w_rend;
    assign o_cmd.frame_last  = w_last;

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_base = r_base;
        n_addr = r_addr;
        if (i_restart) begin
            n_col  = '0;
            n_row  = '0;
            n_base = w_start;
            n_addr = w_start;
        end else if (i_accept) begin
            priority if (w_last) begin
                n_col  = '0;
                n_row  = '0;
                n_base = w_start;
                n_addr = w_start;
            end else if (w_rend) begin
                n_col  = '0;
                n_row  = r_row + CNT_W'(1);
                n_base = w_next_base;
                n_addr = w_next_base;
            end else begin
                n_col  = r_col + CNT_W'(1);
                n_addr = r_addr + ADDR_BITS'(w_nbytes);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_base <= '0;
            r_addr <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_base <= n_base;
            r_addr <= n_addr;
        end
    end

endmodule

>>> hw/rtl/pfub_fifo.sv
module pfub_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  pfub_pkg::t_cmd  i_wdata,
    output logic            o_full,
    input  logic            i_rd,
    output pfub_pkg::t_cmd  o_rdata,
    output logic            o_empty
);
    import pfub_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH < 2) ? 1 : $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_cmd             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> hw/rtl/pfub_back.sv
module pfub_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pfub_pkg::t_kind             i_source_kind,
    input  pfub_pkg::t_cmd              i_cmd,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_take,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [31:0]                 o_dst_address,
    output logic [pfub_pkg::PIX_W-1:0]  o_dst_pixel,
    output logic [pfub_pkg::BCNT_W-1:0] o_dst_byte_count,
    output logic                        o_row_end,
    output logic                        o_frame_last
);
    import pfub_pkg::*;

    logic               r_valid, n_valid;
    logic [31:0]        r_address;
    logic [PIX_W-1:0]   r_pixel, n_pixel;
    logic [BCNT_W-1:0]  r_bcnt;
    logic               r_rend;
    logic               r_last;

    logic [15:0] w_word;
    logic [7:0]  w_r, w_g, w_b, w_a;

    assign w_word     = i_cmd.source_word[15:0];
    assign o_cmd_take = i_cmd_valid && (!r_valid || i_pop);

    always_comb begin
        unique case (i_source_kind)
            KIND_565: begin
                w_r = {w_word[15:11], w_word[15:13]};
                w_g = {w_word[10:5],  w_word[10:9]};
                w_b = {w_word[4:0],   w_word[4:2]};
                w_a = 8'hFF;
            end
            KIND_4444: begin
                w_r = {w_word[15:12], w_word[15:12]};
                w_g = {w_word[11:8],  w_word[11:8]};
                w_b = {w_word[7:4],   w_word[7:4]};
                w_a = {w_word[3:0],   w_word[3:0]};
            end
            KIND_5551: begin
                w_r = {w_word[15:11], w_word[15:13]};
                w_g = {w_word[10:6],  w_word[10:8]};
                w_b = {w_word[5:1],   w_word[5:3]};
                w_a = {8{w_word[0]}};
            end
            default: begin
                w_r = i_cmd.source_word[7:0];
                w_g = i_cmd.source_word[15:8];
                w_b = i_cmd.source_word[23:16];
                w_a = i_cmd.source_word[31:24];
            end
        endcase
    end

    always_comb begin
        unique case (i_cmd.layout)
            LAY_A:   n_pixel = {24'h0, (i_source_kind == KIND_BYTES) ? w_r : w_a};
            LAY_L:   n_pixel = {24'h0, w_r};
            LAY_LA:  n_pixel = {16'h0, (i_source_kind == KIND_BYTES) ? w_g : w_a, w_r};
            LAY_RGB: n_pixel = {8'h0, w_b, w_g, w_r};
            default: n_pixel = {w_a, w_b, w_g, w_r};
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_cmd_take) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_address <= i_cmd.address;
            r_pixel   <= n_pixel;
            r_bcnt    <= i_cmd.byte_count;
            r_rend    <= i_cmd.row_end;
            r_last    <= i_cmd.frame_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_empty          = !r_valid;
    assign o_dst_address    = r_address;
    assign o_dst_pixel      = r_pixel;
    assign o_dst_byte_count = r_bcnt;
    assign o_row_end        = r_rend;
    assign o_frame_last     = r_last;

endmodule

>>> hw/rtl/pixel_format_unpack_blitter.sv
// Throughput: one item per cycle while the queue is not full and results are popped.
// The address add and the channel unpack each take one stage.
// A two-entry queue sits between the address stage and the unpack/output register.
// Reset (synchronous, active low): registers return to their reset values, counters and
// addresses restart at dest_start, both queues read empty. No clearing pass.
module pixel_format_unpack_blitter #(
    parameter int MAX_DIM   = 4096,
    parameter int ADDR_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_push,
    output logic        o_full,
    input  logic [31:0] i_source_word,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [31:0] o_dst_address,
    output logic [31:0] o_dst_pixel,
    output logic [2:0]  o_dst_byte_count,
    output logic        o_row_end,
    output logic        o_frame_last
);
    import pfub_pkg::*;

    t_cfg        r_cfg, n_cfg;
    logic        w_cfg_wr;
    logic        w_restart;
    logic [2:0]  w_idx;
    logic        w_accept;
    t_cmd        w_front_cmd;
    t_cmd        w_fifo_cmd;
    logic        w_fifo_empty;
    logic        w_take;

    assign pready    = 1'b1;
    assign w_idx     = paddr[4:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_accept  = i_push && !o_full;

    always_comb begin
        n_cfg     = r_cfg;
        w_restart = 1'b0;
        if (w_cfg_wr) begin
            w_restart = 1'b1;
            unique case (w_idx)
                REG_SOURCE_KIND:    n_cfg.source_kind    = t_kind'(pwdata[1:0]);
                REG_DEST_LAYOUT:    n_cfg.dest_layout    = pwdata[2:0];
                REG_PIXELS_PER_ROW: n_cfg.pixels_per_row = pwdata[DIM_W-1:0];
                REG_ROW_COUNT:      n_cfg.row_count      = pwdata[DIM_W-1:0];
                REG_DEST_ROW_PITCH: n_cfg.dest_row_pitch = pwdata[15:0];
                REG_DEST_START:     n_cfg.dest_start     = pwdata;
                default:            w_restart            = 1'b0;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SOURCE_KIND:    prdata = {30'h0, r_cfg.source_kind};
            REG_DEST_LAYOUT:    prdata = {29'h0, r_cfg.dest_layout};
            REG_PIXELS_PER_ROW: prdata = {19'h0, r_cfg.pixels_per_row};
            REG_ROW_COUNT:      prdata = {19'h0, r_cfg.row_count};
            REG_DEST_ROW_PITCH: prdata = {16'h0, r_cfg.dest_row_pitch};
            REG_DEST_START:     prdata = r_cfg.dest_start;
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_kind    <= KIND_BYTES;
            r_cfg.dest_layout    <= LAY_RGBA;
            r_cfg.pixels_per_row <= DIM_W'(1);
            r_cfg.row_count      <= DIM_W'(1);
            r_cfg.dest_row_pitch <= '0;
            r_cfg.dest_start     <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    pfub_front #(
        .MAX_DIM   (MAX_DIM),
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (n_cfg),
        .i_restart     (w_restart),
        .i_accept      (w_accept),
        .i_source_word (i_source_word),
        .o_cmd         (w_front_cmd)
    );

    pfub_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_accept),
        .i_wdata (w_front_cmd),
        .o_full  (o_full),
        .i_rd    (w_take),
        .o_rdata (w_fifo_cmd),
        .o_empty (w_fifo_empty)
    );

    pfub_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_source_kind    (r_cfg.source_kind),
        .i_cmd            (w_fifo_cmd),
        .i_cmd_valid      (!w_fifo_empty),
        .o_cmd_take       (w_take),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_dst_address    (o_dst_address),
        .o_dst_pixel      (o_dst_pixel),
        .o_dst_byte_count (o_dst_byte_count),
        .o_row_end        (o_row_end),
        .o_frame_last     (o_frame_last)
    );

endmodule

>>> hw/rtl/pfub_checker.sv
`include "assert_macros.svh"

module pfub_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_pop,
    input logic        o_empty,
    input logic [31:0] o_dst_address,
    input logic [31:0] o_dst_pixel,
    input logic [2:0]  o_dst_byte_count,
    input logic        o_row_end,
    input logic        o_frame_last
);

    `PFUB_ASSERT(a_hold_result, (!o_empty && !i_pop) |=> (!o_empty && $stable(o_dst_pixel) && $stable(o_dst_address)), "result changed before pop")
    `PFUB_ASSERT(a_last_ends_row, (!o_empty && o_frame_last) |-> o_row_end, "frame_last without row_end")
    `PFUB_ASSERT(a_count_range, !o_empty |-> (o_dst_byte_count != 3'd0 && o_dst_byte_count <= 3'd4), "byte count out of range")
    `PFUB_ASSERT(a_upper_zero, (!o_empty && o_dst_byte_count == 3'd1) |-> (o_dst_pixel[31:8] == 24'h0), "bytes above count not zero")

endmodule

bind pixel_format_unpack_blitter pfub_checker u_pfub_checker (.*);

>>> tb/pixel_unpack_checker.sv
`timescale 1ns / 1ps

module pixel_unpack_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [31:0] i_source_word,
    input  logic        i_pop,
    input  logic        i_empty,
    input  logic [31:0] i_dst_address,
    input  logic [31:0] i_dst_pixel,
    input  logic [2:0]  i_dst_byte_count,
    input  logic        i_row_end,
    input  logic        i_frame_last,
    output int          o_pixels_in_flight,
    output int          o_mismatches
);
    import pfub_pkg::*;

    localparam int MAX_DIM = 4096;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] pixel;
        logic [2:0]  byte_count;
        logic        row_end;
        logic        frame_last;
    } t_dst_item;

    t_cfg             blit_cfg;
    logic [DIM_W-1:0] column_at;
    logic [DIM_W-1:0] row_at;
    logic [31:0]      row_base_addr;
    logic [31:0]      pixel_addr;
    t_dst_item        expected_pixels[$];
    t_dst_item        want;
    int               mismatch_count;
    logic             reg_hit;

    initial begin
        o_pixels_in_flight = 0;
        o_mismatches       = 0;
        mismatch_count     = 0;
    end

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic logic [7:0] widen4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic int clamp_dim(input logic [DIM_W-1:0] v);
        if (v == 0) begin
            return 1;
        end
        if (int'(v) > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    function automatic t_dst_item unpack_pixel(input logic [31:0] sp, input t_kind kind,
                                               input logic [2:0] layout);
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic [15:0] w;
        t_dst_item   d;
        w = sp[15:0];
        d = '0;
        case (kind)
            KIND_565: begin
                r = widen5(w[15:11]);
                g = widen6(w[10:5]);
                b = widen5(w[4:0]);
                a = 8'hFF;
            end
            KIND_4444: begin
                r = widen4(w[15:12]);
                g = widen4(w[11:8]);
                b = widen4(w[7:4]);
                a = widen4(w[3:0]);
            end
            KIND_5551: begin
                r = widen5(w[15:11]);
                g = widen5(w[10:6]);
                b = widen5(w[5:1]);
                a = {8{w[0]}};
            end
            default: begin
                r = sp[7:0];
                g = sp[15:8];
                b = sp[23:16];
                a = sp[31:24];
            end
        endcase
        case (layout)
            LAY_A: begin
                d.byte_count = 3'd1;
                d.pixel      = {24'h0, (kind == KIND_BYTES) ? r : a};
            end
            LAY_L: begin
                d.byte_count = 3'd1;
                d.pixel      = {24'h0, r};
            end
            LAY_LA: begin
                d.byte_count = 3'd2;
                d.pixel      = {16'h0, (kind == KIND_BYTES) ? g : a, r};
            end
            LAY_RGB: begin
                d.byte_count = 3'd3;
                d.pixel      = {8'h0, b, g, r};
            end
            default: begin
                d.byte_count = 3'd4;
                d.pixel      = {a, b, g, r};
            end
        endcase
        return d;
    endfunction

    task automatic restart_blit();
        column_at     = '0;
        row_at        = '0;
        row_base_addr = blit_cfg.dest_start;
        pixel_addr    = blit_cfg.dest_start;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blit_cfg.source_kind    = KIND_BYTES;
            blit_cfg.dest_layout    = LAY_RGBA;
            blit_cfg.pixels_per_row = 1;
            blit_cfg.row_count      = 1;
            blit_cfg.dest_row_pitch = '0;
            blit_cfg.dest_start     = '0;
            restart_blit();
            expected_pixels.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                reg_hit = 1'b1;
                case (paddr[4:2])
                    REG_SOURCE_KIND:    blit_cfg.source_kind    = t_kind'(pwdata[1:0]);
                    REG_DEST_LAYOUT:    blit_cfg.dest_layout    = pwdata[2:0];
                    REG_PIXELS_PER_ROW: blit_cfg.pixels_per_row = pwdata[DIM_W-1:0];
                    REG_ROW_COUNT:      blit_cfg.row_count      = pwdata[DIM_W-1:0];
                    REG_DEST_ROW_PITCH: blit_cfg.dest_row_pitch = pwdata[15:0];
                    REG_DEST_START:     blit_cfg.dest_start     = pwdata;
                    default:            reg_hit = 1'b0;
                endcase
                if (reg_hit) begin
                    restart_blit();
                end
            end

            if (i_pop && !i_empty) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected item: dst_address %h dst_pixel %h",
                           i_dst_address, i_dst_pixel);
                    mismatch_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_dst_address !== want.address) begin
                        $error("dst_address: expected %h, got %h", want.address, i_dst_address);
                        mismatch_count++;
                    end
                    if (i_dst_pixel !== want.pixel) begin
                        $error("dst_pixel: expected %h, got %h", want.pixel, i_dst_pixel);
                        mismatch_count++;
                    end
                    if (i_dst_byte_count !== want.byte_count) begin
                        $error("dst_byte_count: expected %0d, got %0d",
                               want.byte_count, i_dst_byte_count);
                        mismatch_count++;
                    end
                    if (i_row_end !== want.row_end) begin
                        $error("row_end: expected %b, got %b", want.row_end, i_row_end);
                        mismatch_count++;
                    end
                    if (i_frame_last !== want.frame_last) begin
                        $error("frame_last: expected %b, got %b", want.frame_last, i_frame_last);
                        mismatch_count++;
                    end
                end
            end

            if (i_push && !i_full) begin
                want = unpack_pixel(i_source_word, blit_cfg.source_kind, blit_cfg.dest_layout);
                want.address    = pixel_addr;
                want.row_end    = (int'(column_at) + 1 >= clamp_dim(blit_cfg.pixels_per_row));
                want.frame_last = want.row_end
                                  && (int'(row_at) + 1 >= clamp_dim(blit_cfg.row_count));
                expected_pixels.push_back(want);
                if (want.frame_last) begin
                    restart_blit();
                end else if (want.row_end) begin
                    column_at     = '0;
                    row_at        = row_at + 1'b1;
                    row_base_addr = row_base_addr + 32'(blit_cfg.dest_row_pitch);
                    pixel_addr    = row_base_addr;
                end else begin
                    column_at  = column_at + 1'b1;
                    pixel_addr = pixel_addr + 32'(want.byte_count);
                end
            end
        end
        o_pixels_in_flight <= expected_pixels.size();
        o_mismatches       <= mismatch_count;
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pfub_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_push;
    logic        o_full;
    logic [31:0] i_source_word;
    logic        i_pop;
    logic        o_empty;
    logic [31:0] o_dst_address;
    logic [31:0] o_dst_pixel;
    logic [2:0]  o_dst_byte_count;
    logic        o_row_end;
    logic        o_frame_last;

    int pixels_in_flight;
    int mismatches;
    bit tx_idle;
    bit rx_idle;
    bit rx_hold;

    pixel_format_unpack_blitter DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_source_word    (i_source_word),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_dst_address    (o_dst_address),
        .o_dst_pixel      (o_dst_pixel),
        .o_dst_byte_count (o_dst_byte_count),
        .o_row_end        (o_row_end),
        .o_frame_last     (o_frame_last)
    );

    pixel_unpack_checker pixel_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .pready             (pready),
        .i_push             (i_push),
        .i_full             (o_full),
        .i_source_word      (i_source_word),
        .i_pop              (i_pop),
        .i_empty            (o_empty),
        .i_dst_address      (o_dst_address),
        .i_dst_pixel        (o_dst_pixel),
        .i_dst_byte_count   (o_dst_byte_count),
        .i_row_end          (o_row_end),
        .i_frame_last       (o_frame_last),
        .o_pixels_in_flight (pixels_in_flight),
        .o_mismatches       (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold until the block has drained, then restart the blit with new settings
    task automatic configure(input t_kind kind, input logic [2:0] layout,
                             input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height,
                             input logic [15:0] pitch, input logic [31:0] start);
        logic [31:0] junk;
        junk = $urandom();
        @(posedge i_clk);
        wait (pixels_in_flight == 0);
        write_reg(REG_SOURCE_KIND, {junk[31:2], kind});
        write_reg(REG_DEST_LAYOUT, {junk[31:3], layout});
        write_reg(REG_PIXELS_PER_ROW, {junk[31:DIM_W], width});
        write_reg(REG_ROW_COUNT, {junk[31:DIM_W], height});
        write_reg(REG_DEST_ROW_PITCH, {junk[31:16], pitch});
        write_reg(REG_DEST_START, start);
    endtask

    task automatic push_pixel(input logic [31:0] value);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push        <= 1'b1;
        i_source_word <= value;
        do @(posedge i_clk); while (o_full);
    endtask

    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            if (rx_hold) begin
                i_pop <= 1'b0;
                repeat (400) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            gap = rx_idle ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                i_pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty);
        end
    end

    initial begin
        logic [31:0]      corner_pixels[4];
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [31:0]      start;
        int               sent;
        int               count;
        int               pick;

        corner_pixels = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5A3C_0001, 32'hA5C3_FFFE};
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_push        = 1'b0;
        i_source_word = '0;
        i_pop         = 1'b0;
        tx_idle       = 1'b0;
        rx_idle       = 1'b0;
        rx_hold       = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero size acts as a single pixel; each item ends the blit
        configure(KIND_BYTES, LAY_RGBA, '0, '0, 16'hFFFF, 32'hFFFF_FFFF);
        push_pixel(32'hFFFF_FFFF);
        push_pixel(32'h0000_0000);
        i_push <= 1'b0;

        for (int k = 0; k < 4; k++) begin
            for (int l = 0; l < 5; l++) begin
                configure(t_kind'(k), 3'(l), 13'd3, 13'd2, 16'h0100, 32'h0000_1000);
                push_pixel(corner_pixels[(k * 5 + l) % 4]);
                i_push <= 1'b0;
            end
        end

        for (int l = 5; l < 8; l++) begin
            configure(KIND_4444, 3'(l), 13'd1, 13'd1, 16'h0000, 32'h8000_0000);
            push_pixel(32'h1234_5678);
            i_push <= 1'b0;
        end

        sent = 0;
        while (sent < 450) begin
            pick = $urandom_range(0, 9);
            width = (pick == 0) ? 13'd0 :
                    (pick == 1) ? 13'($urandom_range(4097, 8191)) :
                    (pick == 2) ? 13'd4096 : 13'($urandom_range(1, 6));
            pick = $urandom_range(0, 9);
            height = (pick == 0) ? 13'd0 :
                     (pick == 1) ? 13'($urandom_range(4097, 8191)) :
                     (pick == 2) ? 13'd4096 : 13'($urandom_range(1, 5));
            start = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                                : $urandom();
            configure(t_kind'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), width, height,
                      16'($urandom_range(0, 65535)), start);
            count = $urandom_range(8, 40);
            if (sent == 0) begin
                // stall the receiver while items keep coming so the block backs up
                tx_idle = 1'b0;
                rx_idle = 1'b0;
                rx_hold = 1'b1;
                count   = 40;
            end else begin
                tx_idle = $urandom_range(0, 1);
                rx_idle = $urandom_range(0, 1);
            end
            repeat (count) push_pixel($urandom());
            i_push <= 1'b0;
            sent += count;
        end

        @(posedge i_clk);
        wait (pixels_in_flight == 0);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
